@@ rtl/tqws_pkg.sv @@
package tqws_pkg;

  localparam int TagWidth        = 16;
  localparam int BurstWidth      = 4;
  localparam int QueueDepthDflt  = 16;
  localparam logic [BurstWidth-1:0] BurstReset = 4'd3;

  typedef enum logic [1:0] {
    CMD_ENQ_NORMAL   = 2'd0,
    CMD_ENQ_PRIORITY = 2'd1,
    CMD_SERVE        = 2'd2
  } command_e;

  typedef enum logic [2:0] {
    ST_ENQUEUED      = 3'd0,
    ST_REJECTED      = 3'd1,
    ST_SERVED_NORMAL = 3'd2,
    ST_SERVED_PRIO   = 3'd3,
    ST_WAITING       = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [TagWidth-1:0] item_tag;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [TagWidth-1:0] served_tag;
  } result_t;

  // Per-cell control: shared push/pop plus occupancy of both neighbors.
  typedef struct packed {
    logic push;
    logic pop;
    logic left_valid;
    logic right_valid;
  } cell_ctrl_t;

endpackage

@@ rtl/tqws_cell.sv @@
module tqws_cell import tqws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic [TagWidth-1:0] push_tag,
  input  logic [TagWidth-1:0] right_tag,
  output logic                valid,
  output logic [TagWidth-1:0] tag
);

  logic take_push;

  // The first empty cell of the row takes the pushed tag.
  assign take_push = ctrl.push && !valid && ctrl.left_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= ctrl.right_valid;
    end else if (take_push) begin
      valid <= 1'b1;
    end
  end

  // Shift toward the head on pop.
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      tag <= right_tag;
    end else if (take_push) begin
      tag <= push_tag;
    end
  end

endmodule

@@ rtl/tqws_fifo.sv @@
module tqws_fifo import tqws_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDflt
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                pop,
  input  logic [TagWidth-1:0] push_tag,
  output logic                empty,
  output logic                full,
  output logic [TagWidth-1:0] head_tag
);

  logic [QUEUE_DEPTH-1:0] valid;
  logic [TagWidth-1:0]    tags [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t          ctrl;
    logic [TagWidth-1:0] right_tag;

    if (i == 0) begin : g_first
      assign ctrl.left_valid = 1'b1;
    end else begin : g_inner_l
      assign ctrl.left_valid = valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign ctrl.right_valid = 1'b0;
      assign right_tag        = '0;
    end else begin : g_inner_r
      assign ctrl.right_valid = valid[i+1];
      assign right_tag        = tags[i+1];
    end

    assign ctrl.push = push;
    assign ctrl.pop  = pop;

    tqws_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .push_tag  (push_tag),
      .right_tag (right_tag),
      .valid     (valid[i]),
      .tag       (tags[i])
    );
  end

  assign empty    = !valid[0];
  assign full     = valid[QUEUE_DEPTH-1];
  assign head_tag = tags[0];

endmodule

@@ rtl/two_queue_weighted_server_top.sv @@
// Channel   | Handshake       | Payload               | Direction
// ----------+-----------------+-----------------------+----------
// command   | start / busy    | cmd (command,item_tag)| in
// result    | done (strobe)   | result (status,tag)   | out
// config    | cfg_we          | cfg_wdata (burst_limit)| in
//
// Each command's result, with done high, is shown in the cycle after the
// transaction is accepted; the done and result registers lie between. busy
// stays low, so one transaction can be accepted every cycle.
// rst is synchronous: it empties both queues, clears the priority run and
// loads burst_limit with 3. The receiver cannot stall; each result is shown
// for exactly one cycle.
module two_queue_weighted_server_top import tqws_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDflt
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd,
  input  logic                  cfg_we,
  input  logic [BurstWidth-1:0] cfg_wdata,
  output logic                  done,
  output result_t               result
);

  logic                  accept;
  logic [BurstWidth-1:0] burst_limit;
  logic [BurstWidth-1:0] run;
  logic [BurstWidth-1:0] run_next;
  result_t               result_next;

  logic                  n_push, n_pop, n_empty, n_full;
  logic                  p_push, p_pop, p_empty, p_full;
  logic [TagWidth-1:0]   n_head, p_head;
  logic                  prio_first;

  // Every command completes in its own cycle, so never hold off the source.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Burst limit register; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_limit <= BurstReset;
    end else if (cfg_we) begin
      burst_limit <= cfg_wdata;
    end
  end

  tqws_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_normal (
    .clk      (clk),
    .rst      (rst),
    .push     (n_push),
    .pop      (n_pop),
    .push_tag (cmd.item_tag),
    .empty    (n_empty),
    .full     (n_full),
    .head_tag (n_head)
  );

  tqws_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_priority (
    .clk      (clk),
    .rst      (rst),
    .push     (p_push),
    .pop      (p_pop),
    .push_tag (cmd.item_tag),
    .empty    (p_empty),
    .full     (p_full),
    .head_tag (p_head)
  );

  // A run below the limit favors the priority queue; a run at or past the
  // limit (also after the limit is lowered) gives the normal queue a turn.
  assign prio_first = run < burst_limit;

  always_comb begin
    n_push      = 1'b0;
    p_push      = 1'b0;
    n_pop       = 1'b0;
    p_pop       = 1'b0;
    run_next    = run;
    result_next = '{status: ST_REJECTED, served_tag: '0};
    if (accept) begin
      case (command_e'(cmd.command))
        CMD_ENQ_NORMAL: begin
          if (!n_full) begin
            n_push             = 1'b1;
            result_next.status = ST_ENQUEUED;
          end
        end
        CMD_ENQ_PRIORITY: begin
          if (!p_full) begin
            p_push             = 1'b1;
            result_next.status = ST_ENQUEUED;
          end
        end
        CMD_SERVE: begin
          if (prio_first && !p_empty) begin
            p_pop       = 1'b1;
            run_next    = run + 1'b1;
            result_next = '{status: ST_SERVED_PRIO, served_tag: p_head};
          end else if (!n_empty) begin
            n_pop       = 1'b1;
            run_next    = '0;
            result_next = '{status: ST_SERVED_NORMAL, served_tag: n_head};
          end else if (!p_empty) begin
            // Normal queue dry: keep serving priority, run holds.
            p_pop       = 1'b1;
            result_next = '{status: ST_SERVED_PRIO, served_tag: p_head};
          end else begin
            result_next.status = ST_WAITING;
          end
        end
        default: begin
          // Unused command code: reject, no state change.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= '0;
      done <= 1'b0;
    end else begin
      run  <= run_next;
      done <= accept;
    end
  end

  // Result payload needs no reset; done qualifies it.
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result strobe without an accepted transaction");

  a_normal_clears_run: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_SERVED_NORMAL |-> run == '0)
    else $error("priority run not cleared after a normal serve");

  a_idle_tag_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_WAITING || result.status == ST_ENQUEUED ||
             result.status == ST_REJECTED) |-> result.served_tag == '0)
    else $error("served tag nonzero although nothing was served");

  a_single_pop: assert property (@(posedge clk) disable iff (rst)
    !(n_pop && p_pop) && !(n_push && p_push))
    else $error("both queues moved by one transaction");

endmodule
